/* design/cpu8eu_pkg.sv */
// Shared types, operation codes and helpers for the cpu8 execute unit.
// No dependencies; the execute logic and the top level refer to it by scoped names.
`default_nettype none

package cpu8eu_pkg;

    localparam logic [7:0] STATUS_FIXED = 8'h30;
    localparam logic [7:0] SP_RESET     = 8'hFF;

    typedef enum logic [5:0] {
        OP_LDA   = 6'd0,  OP_LDX   = 6'd1,  OP_LDY   = 6'd2,  OP_STA   = 6'd3,
        OP_STX   = 6'd4,  OP_STY   = 6'd5,  OP_TAX   = 6'd6,  OP_TAY   = 6'd7,
        OP_TSX   = 6'd8,  OP_TXA   = 6'd9,  OP_TXS   = 6'd10, OP_TYA   = 6'd11,
        OP_PHA   = 6'd12, OP_PHP   = 6'd13, OP_PLA   = 6'd14, OP_PLP   = 6'd15,
        OP_AND   = 6'd16, OP_EOR   = 6'd17, OP_ORA   = 6'd18, OP_BIT   = 6'd19,
        OP_ADC   = 6'd20, OP_SBC   = 6'd21, OP_CMP   = 6'd22, OP_CPX   = 6'd23,
        OP_CPY   = 6'd24, OP_INC   = 6'd25, OP_DEC   = 6'd26, OP_INX   = 6'd27,
        OP_INY   = 6'd28, OP_DEX   = 6'd29, OP_DEY   = 6'd30, OP_CLC   = 6'd31,
        OP_CLD   = 6'd32, OP_CLI   = 6'd33, OP_CLV   = 6'd34, OP_BCC   = 6'd35,
        OP_BCS   = 6'd36, OP_BEQ   = 6'd37, OP_BMI   = 6'd38, OP_BNE   = 6'd39,
        OP_BPL   = 6'd40, OP_BVC   = 6'd41, OP_BVS   = 6'd42, OP_ROL_A = 6'd43,
        OP_ROR_A = 6'd44, OP_LSR_A = 6'd45, OP_ASL_A = 6'd46, OP_ROL_M = 6'd47,
        OP_ROR_M = 6'd48, OP_LSR_M = 6'd49, OP_ASL_M = 6'd50, OP_NOP   = 6'd51
    } op_t;

    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_WRITE = 2'd1,
        ACC_PUSH  = 2'd2,
        ACC_PULL  = 2'd3
    } access_t;

    typedef enum logic [1:0] {
        SH_ROL = 2'd0,
        SH_ROR = 2'd1,
        SH_LSR = 2'd2,
        SH_ASL = 2'd3
    } shift_t;

    // Architectural state
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic       c;
        logic       z;
        logic       i;
        logic       d;
        logic       v;
        logic       n;
    } regs_t;

    // One result word
    typedef struct packed {
        access_t    kind;
        logic [7:0] wdata;
        logic [7:0] saddr;
        logic       taken;
        logic [7:0] status;
    } res_t;

    localparam regs_t REGS_RESET = '{
        a: 8'h00, x: 8'h00, y: 8'h00, sp: SP_RESET,
        c: 1'b0, z: 1'b0, i: 1'b0, d: 1'b0, v: 1'b0, n: 1'b0
    };

    function automatic logic [7:0] pack_status(input regs_t r);
        logic [7:0] s;
        s = STATUS_FIXED;
        s[0] = r.c;
        s[1] = r.z;
        s[2] = r.i;
        s[3] = r.d;
        s[6] = r.v;
        s[7] = r.n;
        return s;
    endfunction

endpackage

`default_nettype wire

/* design/cpu8eu_cmd_if.sv */
// Command channel: operation code and operand byte, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface cpu8eu_cmd_if;
    logic       valid;
    logic       ready;
    logic [5:0] operation;
    logic [7:0] operand;

    modport source (output valid, output operation, output operand, input ready);
    modport sink   (input valid, input operation, input operand, output ready);
endinterface

`default_nettype wire

/* design/cpu8eu_rsp_if.sv */
// Response channel: memory/stack access, branch decision and status byte.
// Depends on nothing.
`default_nettype none

interface cpu8eu_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] access_kind;
    logic [7:0] write_data;
    logic [7:0] stack_address;
    logic       branch_taken;
    logic [7:0] status_byte;

    modport source (output valid, output access_kind, output write_data,
                    output stack_address, output branch_taken, output status_byte,
                    input ready);
    modport sink   (input valid, input access_kind, input write_data,
                    input stack_address, input branch_taken, input status_byte,
                    output ready);
endinterface

`default_nettype wire

/* design/cpu8eu_alu.sv */
// Combinational execute logic: next architectural state and result word.
// Depends on cpu8eu_pkg.
`default_nettype none

module cpu8eu_alu (
    input  wire cpu8eu_pkg::regs_t cur,
    input  wire logic [5:0]        operation,
    input  wire logic [7:0]        operand,
    output cpu8eu_pkg::regs_t      nxt,
    output cpu8eu_pkg::res_t       res
);

    cpu8eu_pkg::op_t op;
    logic [7:0]      addend;
    logic [8:0]      sum9;
    logic [7:0]      cmp_src;
    logic [8:0]      diff9;
    logic [7:0]      val;
    logic [8:0]      sh9;

    assign op = cpu8eu_pkg::op_t'(operation);

    // {N, Z} of a byte
    function automatic logic [1:0] nz(input logic [7:0] v);
        return {v[7], v == 8'h00};
    endfunction

    // returns {carry out, result}
    function automatic logic [8:0] shift_byte(input cpu8eu_pkg::shift_t kind,
                                              input logic [7:0] v,
                                              input logic cin);
        logic [8:0] r;
        case (kind)
            cpu8eu_pkg::SH_ROL: r = {v[7], v[6:0], cin};
            cpu8eu_pkg::SH_ROR: r = {v[0], cin, v[7:1]};
            cpu8eu_pkg::SH_LSR: r = {v[0], 1'b0, v[7:1]};
            default:            r = {v[7], v[6:0], 1'b0};
        endcase
        return r;
    endfunction

    // shared adder for ADC/SBC, shared subtractor for the compares
    assign addend = (op == cpu8eu_pkg::OP_SBC) ? ~operand : operand;
    assign sum9   = {1'b0, cur.a} + {1'b0, addend} + {8'h00, cur.c};

    always_comb
    begin
        case (op)
            cpu8eu_pkg::OP_CPX: cmp_src = cur.x;
            cpu8eu_pkg::OP_CPY: cmp_src = cur.y;
            default:            cmp_src = cur.a;
        endcase
    end

    assign diff9 = {1'b0, cmp_src} - {1'b0, operand};

    always_comb
    begin
        nxt       = cur;
        res.kind  = cpu8eu_pkg::ACC_NONE;
        res.wdata = 8'h00;
        res.saddr = 8'h00;
        res.taken = 1'b0;
        val       = 8'h00;
        sh9       = 9'h000;
        case (op)
            cpu8eu_pkg::OP_LDA:
            begin
                nxt.a = operand;
                {nxt.n, nxt.z} = nz(operand);
            end
            cpu8eu_pkg::OP_LDX:
            begin
                nxt.x = operand;
                {nxt.n, nxt.z} = nz(operand);
            end
            cpu8eu_pkg::OP_LDY:
            begin
                nxt.y = operand;
                {nxt.n, nxt.z} = nz(operand);
            end
            cpu8eu_pkg::OP_STA:
            begin
                res.kind  = cpu8eu_pkg::ACC_WRITE;
                res.wdata = cur.a;
            end
            cpu8eu_pkg::OP_STX:
            begin
                res.kind  = cpu8eu_pkg::ACC_WRITE;
                res.wdata = cur.x;
            end
            cpu8eu_pkg::OP_STY:
            begin
                res.kind  = cpu8eu_pkg::ACC_WRITE;
                res.wdata = cur.y;
            end
            cpu8eu_pkg::OP_TAX:
            begin
                nxt.x = cur.a;
                {nxt.n, nxt.z} = nz(cur.a);
            end
            cpu8eu_pkg::OP_TAY:
            begin
                nxt.y = cur.a;
                {nxt.n, nxt.z} = nz(cur.a);
            end
            cpu8eu_pkg::OP_TSX:
            begin
                nxt.x = cur.sp;
                {nxt.n, nxt.z} = nz(cur.sp);
            end
            cpu8eu_pkg::OP_TXA:
            begin
                nxt.a = cur.x;
                {nxt.n, nxt.z} = nz(cur.x);
            end
            cpu8eu_pkg::OP_TXS:
            begin
                nxt.sp = cur.x;
            end
            cpu8eu_pkg::OP_TYA:
            begin
                nxt.a = cur.y;
                {nxt.n, nxt.z} = nz(cur.y);
            end
            cpu8eu_pkg::OP_PHA, cpu8eu_pkg::OP_PHP:
            begin
                res.kind  = cpu8eu_pkg::ACC_PUSH;
                res.wdata = (op == cpu8eu_pkg::OP_PHA) ? cur.a
                                                       : cpu8eu_pkg::pack_status(cur);
                res.saddr = cur.sp;
                nxt.sp    = cur.sp - 8'd1;
            end
            cpu8eu_pkg::OP_PLA:
            begin
                res.kind  = cpu8eu_pkg::ACC_PULL;
                res.saddr = cur.sp + 8'd1;
                nxt.sp    = cur.sp + 8'd1;
                nxt.a     = operand;
                {nxt.n, nxt.z} = nz(operand);
            end
            cpu8eu_pkg::OP_PLP:
            begin
                res.kind  = cpu8eu_pkg::ACC_PULL;
                res.saddr = cur.sp + 8'd1;
                nxt.sp    = cur.sp + 8'd1;
                nxt.c     = operand[0];
                nxt.z     = operand[1];
                nxt.i     = operand[2];
                nxt.d     = operand[3];
                nxt.v     = operand[6];
                nxt.n     = operand[7];
            end
            cpu8eu_pkg::OP_AND:
            begin
                val   = cur.a & operand;
                nxt.a = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_EOR:
            begin
                val   = cur.a ^ operand;
                nxt.a = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_ORA:
            begin
                val   = cur.a | operand;
                nxt.a = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_BIT:
            begin
                nxt.z = (cur.a & operand) == 8'h00;
                nxt.v = operand[6];
                nxt.n = operand[7];
            end
            cpu8eu_pkg::OP_ADC, cpu8eu_pkg::OP_SBC:
            begin
                nxt.v = ~(cur.a[7] ^ addend[7]) & (cur.a[7] ^ sum9[7]);
                nxt.c = sum9[8];
                nxt.a = sum9[7:0];
                {nxt.n, nxt.z} = nz(sum9[7:0]);
            end
            cpu8eu_pkg::OP_CMP, cpu8eu_pkg::OP_CPX, cpu8eu_pkg::OP_CPY:
            begin
                nxt.c = ~diff9[8];
                nxt.z = diff9[7:0] == 8'h00;
                nxt.n = diff9[7];
            end
            cpu8eu_pkg::OP_INC:
            begin
                val       = operand + 8'd1;
                res.kind  = cpu8eu_pkg::ACC_WRITE;
                res.wdata = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_DEC:
            begin
                val       = operand - 8'd1;
                res.kind  = cpu8eu_pkg::ACC_WRITE;
                res.wdata = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_INX:
            begin
                val   = cur.x + 8'd1;
                nxt.x = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_INY:
            begin
                val   = cur.y + 8'd1;
                nxt.y = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_DEX:
            begin
                val   = cur.x - 8'd1;
                nxt.x = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_DEY:
            begin
                val   = cur.y - 8'd1;
                nxt.y = val;
                {nxt.n, nxt.z} = nz(val);
            end
            cpu8eu_pkg::OP_CLC: nxt.c = 1'b0;
            cpu8eu_pkg::OP_CLD: nxt.d = 1'b0;
            cpu8eu_pkg::OP_CLI: nxt.i = 1'b0;
            cpu8eu_pkg::OP_CLV: nxt.v = 1'b0;
            cpu8eu_pkg::OP_BCC: res.taken = ~cur.c;
            cpu8eu_pkg::OP_BCS: res.taken = cur.c;
            cpu8eu_pkg::OP_BEQ: res.taken = cur.z;
            cpu8eu_pkg::OP_BMI: res.taken = cur.n;
            cpu8eu_pkg::OP_BNE: res.taken = ~cur.z;
            cpu8eu_pkg::OP_BPL: res.taken = ~cur.n;
            cpu8eu_pkg::OP_BVC: res.taken = ~cur.v;
            cpu8eu_pkg::OP_BVS: res.taken = cur.v;
            cpu8eu_pkg::OP_ROL_A, cpu8eu_pkg::OP_ROR_A,
            cpu8eu_pkg::OP_LSR_A, cpu8eu_pkg::OP_ASL_A:
            begin
                case (op)
                    cpu8eu_pkg::OP_ROL_A: sh9 = shift_byte(cpu8eu_pkg::SH_ROL, cur.a, cur.c);
                    cpu8eu_pkg::OP_ROR_A: sh9 = shift_byte(cpu8eu_pkg::SH_ROR, cur.a, cur.c);
                    cpu8eu_pkg::OP_LSR_A: sh9 = shift_byte(cpu8eu_pkg::SH_LSR, cur.a, cur.c);
                    default:              sh9 = shift_byte(cpu8eu_pkg::SH_ASL, cur.a, cur.c);
                endcase
                nxt.c = sh9[8];
                nxt.a = sh9[7:0];
                {nxt.n, nxt.z} = nz(sh9[7:0]);
            end
            cpu8eu_pkg::OP_ROL_M, cpu8eu_pkg::OP_ROR_M,
            cpu8eu_pkg::OP_LSR_M, cpu8eu_pkg::OP_ASL_M:
            begin
                case (op)
                    cpu8eu_pkg::OP_ROL_M: sh9 = shift_byte(cpu8eu_pkg::SH_ROL, operand, cur.c);
                    cpu8eu_pkg::OP_ROR_M: sh9 = shift_byte(cpu8eu_pkg::SH_ROR, operand, cur.c);
                    cpu8eu_pkg::OP_LSR_M: sh9 = shift_byte(cpu8eu_pkg::SH_LSR, operand, cur.c);
                    default:              sh9 = shift_byte(cpu8eu_pkg::SH_ASL, operand, cur.c);
                endcase
                nxt.c     = sh9[8];
                res.kind  = cpu8eu_pkg::ACC_WRITE;
                res.wdata = sh9[7:0];
                {nxt.n, nxt.z} = nz(sh9[7:0]);
            end
            default:
            begin
                // NOP and unused codes: no change
            end
        endcase
        res.status = cpu8eu_pkg::pack_status(nxt);
    end

endmodule

`default_nettype wire

/* design/cpu8_execute_unit.sv */
// Top level of the cpu8 execute unit: command register, execute logic, result register.
// Depends on cpu8eu_pkg, cpu8eu_cmd_if, cpu8eu_rsp_if and cpu8eu_alu.
`default_nettype none

// cpu8_execute_unit runs one 6502-style operation per command word and
// returns one response word for it. Throughput is one word per clock while
// the response side is not stalled: the execute logic reads the register
// file and flags, and writes them back in the same cycle the command leaves
// the command register, so a dependent operation can follow directly. The
// command register loads at the accepting edge, and the result register,
// which drives response valid, loads when the command leaves the command
// register, at the same edge that updates the state. The command
// side keeps accepting while a response is waiting, as long as the command
// register is empty or draining into the result register; with the response
// side stalled it holds at most two words (one in each register). ADC and
// SBC are binary only; the D flag is stored and reported but never alters
// arithmetic. Undefined operation codes behave as NOP. write_data reads zero
// unless access_kind is a write or push, stack_address reads zero unless it
// is a push or pull; stack_address is the pointer before decrement for a
// push and after increment for a pull (stack page 0x01 is implied).

module cpu8_execute_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cpu8eu_cmd_if.sink       cmd,
    cpu8eu_rsp_if.source     rsp
);

    // command register
    logic       cmd_valid_reg;
    logic [5:0] cmd_op_reg;
    logic [7:0] cmd_operand_reg;

    // architectural state
    cpu8eu_pkg::regs_t regs_reg;
    cpu8eu_pkg::regs_t regs_next;

    // result register
    logic              rsp_valid_reg;
    cpu8eu_pkg::res_t  res_reg;
    cpu8eu_pkg::res_t  res_next;

    logic advance;   // command register moves into result register
    logic cmd_take;

    assign advance  = cmd_valid_reg & (~rsp_valid_reg | rsp.ready);
    assign cmd.ready = ~cmd_valid_reg | advance;
    assign cmd_take = cmd.valid & cmd.ready;

    cpu8eu_alu u_alu (
        .cur       (regs_reg),
        .operation (cmd_op_reg),
        .operand   (cmd_operand_reg),
        .nxt       (regs_next),
        .res       (res_next)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            regs_reg      <= cpu8eu_pkg::REGS_RESET;
        end
        else
        begin
            if (cmd.ready)
            begin
                cmd_valid_reg <= cmd.valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                regs_reg      <= regs_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cmd_op_reg      <= cmd.operation;
            cmd_operand_reg <= cmd.operand;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.access_kind   = res_reg.kind;
    assign rsp.write_data    = res_reg.wdata;
    assign rsp.stack_address = res_reg.saddr;
    assign rsp.branch_taken  = res_reg.taken;
    assign rsp.status_byte   = res_reg.status;

    // state only moves when a word is executed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(regs_reg))
        else $error("state changed without an executed word");

    // push lowers the stack pointer by one
    a_push_sp: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (cmd_op_reg == cpu8eu_pkg::OP_PHA || cmd_op_reg == cpu8eu_pkg::OP_PHP)
        |=> regs_reg.sp == $past(regs_reg.sp) - 8'd1)
        else $error("push did not decrement stack pointer");

    // fixed status bits always set
    a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> res_reg.status[5:4] == 2'b11)
        else $error("status bits 5:4 not set");

    // no write data without a write or push
    a_wdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (res_reg.kind == cpu8eu_pkg::ACC_NONE ||
                          res_reg.kind == cpu8eu_pkg::ACC_PULL)
        |-> res_reg.wdata == 8'h00)
        else $error("write data set without a write");

    // a stalled response never loses a word from either register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready && cmd_valid_reg |=> rsp_valid_reg && cmd_valid_reg)
        else $error("word dropped under backpressure");

endmodule

`default_nettype wire

/* verif/tb_cpu8_execute_unit.sv */
// Self-checking testbench for cpu8_execute_unit: directed rows, then random words.
// Depends on cpu8eu_pkg, cpu8eu_cmd_if, cpu8eu_rsp_if and the design top level.
`default_nettype none

module tb_cpu8_execute_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cpu8eu_pkg::*;

    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 800;
    localparam int N_WORDS      = N_DIRECTED + N_RANDOM;
    localparam int IDLE_PCT     = 6;    // chance in 100 that a side idles in a cycle
    localparam int CALM_FROM    = 300;  // no idling on either side in this window
    localparam int CALM_TO      = 450;
    localparam int HOLD_AT      = 150;  // response side backs off once, here
    localparam int HOLD_CYCLES  = 64;
    localparam int DRAIN_CYCLES = 8;    // two-stage pipe, plus margin
    localparam int STALL_LIMIT  = 400;  // cycles with no accepted word on either side

    // One directed row; want is only meaningful when known is set
    typedef struct packed {
        logic [5:0] op;
        logic [7:0] arg;
        logic       known;
        res_t       want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    cpu8eu_cmd_if cmd_bus ();
    cpu8eu_rsp_if rsp_bus ();

    cpu8_execute_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // ------------------------------------------------------------------
    // Predicted architectural state, updated once per accepted command word
    // ------------------------------------------------------------------
    regs_t cpu = REGS_RESET;

    function automatic logic [7:0] status_of(input regs_t r);
        // bits 5 and 4 always read as one
        return {r.n, r.v, 2'b11, r.d, r.i, r.z, r.c};
    endfunction

    function automatic void set_nz(input logic [7:0] v);
        cpu.z = (v == 8'h00);
        cpu.n = v[7];
    endfunction

    function automatic logic [7:0] shift_val(input shift_t how, input logic [7:0] v);
        logic [7:0] r;
        case (how)
            SH_ROL:
            begin
                r     = {v[6:0], cpu.c};
                cpu.c = v[7];
            end
            SH_ROR:
            begin
                r     = {cpu.c, v[7:1]};
                cpu.c = v[0];
            end
            SH_LSR:
            begin
                r     = {1'b0, v[7:1]};
                cpu.c = v[0];
            end
            default:
            begin
                r     = {v[6:0], 1'b0};
                cpu.c = v[7];
            end
        endcase
        set_nz(r);
        return r;
    endfunction

    // Binary add only; SBC feeds the inverted operand through here
    function automatic void add_into_a(input logic [7:0] b);
        logic [8:0] sum;
        sum   = {1'b0, cpu.a} + {1'b0, b} + {8'h00, cpu.c};
        cpu.v = ~(cpu.a[7] ^ b[7]) & (cpu.a[7] ^ sum[7]);
        cpu.c = sum[8];
        cpu.a = sum[7:0];
        set_nz(cpu.a);
    endfunction

    function automatic void compare_with(input logic [7:0] r, input logic [7:0] b);
        logic [7:0] diff;
        diff  = r - b;
        cpu.c = (r >= b);
        cpu.z = (r == b);
        cpu.n = diff[7];
    endfunction

    function automatic res_t execute_op(input logic [5:0] code, input logic [7:0] b);
        res_t       o;
        logic [5:0] rel;
        o   = '0;
        // shift kind: same low two bits for the accumulator and memory forms
        rel = code - OP_ROL_A;
        case (code)
            OP_LDA: begin cpu.a = b; set_nz(b); end
            OP_LDX: begin cpu.x = b; set_nz(b); end
            OP_LDY: begin cpu.y = b; set_nz(b); end
            OP_STA: begin o.kind = ACC_WRITE; o.wdata = cpu.a; end
            OP_STX: begin o.kind = ACC_WRITE; o.wdata = cpu.x; end
            OP_STY: begin o.kind = ACC_WRITE; o.wdata = cpu.y; end
            OP_TAX: begin cpu.x = cpu.a;  set_nz(cpu.x); end
            OP_TAY: begin cpu.y = cpu.a;  set_nz(cpu.y); end
            OP_TSX: begin cpu.x = cpu.sp; set_nz(cpu.x); end
            OP_TXA: begin cpu.a = cpu.x;  set_nz(cpu.a); end
            OP_TXS: cpu.sp = cpu.x;   // flags untouched
            OP_TYA: begin cpu.a = cpu.y;  set_nz(cpu.a); end
            OP_PHA, OP_PHP:
            begin
                o.kind  = ACC_PUSH;
                o.wdata = (code == OP_PHA) ? cpu.a : status_of(cpu);
                o.saddr = cpu.sp;
                cpu.sp  = cpu.sp - 8'd1;
            end
            OP_PLA, OP_PLP:
            begin
                o.kind  = ACC_PULL;
                cpu.sp  = cpu.sp + 8'd1;
                o.saddr = cpu.sp;
                if (code == OP_PLA)
                begin
                    cpu.a = b;
                    set_nz(b);
                end
                else
                begin
                    // bits 5 and 4 of the pulled byte are dropped
                    {cpu.n, cpu.v}               = b[7:6];
                    {cpu.d, cpu.i, cpu.z, cpu.c} = b[3:0];
                end
            end
            OP_AND: begin cpu.a = cpu.a & b; set_nz(cpu.a); end
            OP_EOR: begin cpu.a = cpu.a ^ b; set_nz(cpu.a); end
            OP_ORA: begin cpu.a = cpu.a | b; set_nz(cpu.a); end
            OP_BIT:
            begin
                cpu.z = ((cpu.a & b) == 8'h00);
                cpu.v = b[6];
                cpu.n = b[7];
            end
            OP_ADC: add_into_a(b);
            OP_SBC: add_into_a(~b);
            OP_CMP: compare_with(cpu.a, b);
            OP_CPX: compare_with(cpu.x, b);
            OP_CPY: compare_with(cpu.y, b);
            OP_INC: begin o.kind = ACC_WRITE; o.wdata = b + 8'd1; set_nz(o.wdata); end
            OP_DEC: begin o.kind = ACC_WRITE; o.wdata = b - 8'd1; set_nz(o.wdata); end
            OP_INX: begin cpu.x = cpu.x + 8'd1; set_nz(cpu.x); end
            OP_INY: begin cpu.y = cpu.y + 8'd1; set_nz(cpu.y); end
            OP_DEX: begin cpu.x = cpu.x - 8'd1; set_nz(cpu.x); end
            OP_DEY: begin cpu.y = cpu.y - 8'd1; set_nz(cpu.y); end
            OP_CLC: cpu.c = 1'b0;
            OP_CLD: cpu.d = 1'b0;
            OP_CLI: cpu.i = 1'b0;
            OP_CLV: cpu.v = 1'b0;
            OP_BCC: o.taken = !cpu.c;
            OP_BCS: o.taken = cpu.c;
            OP_BEQ: o.taken = cpu.z;
            OP_BMI: o.taken = cpu.n;
            OP_BNE: o.taken = !cpu.z;
            OP_BPL: o.taken = !cpu.n;
            OP_BVC: o.taken = !cpu.v;
            OP_BVS: o.taken = cpu.v;
            OP_ROL_A, OP_ROR_A, OP_LSR_A, OP_ASL_A:
                cpu.a = shift_val(shift_t'(rel[1:0]), cpu.a);
            OP_ROL_M, OP_ROR_M, OP_LSR_M, OP_ASL_M:
            begin
                o.kind  = ACC_WRITE;
                o.wdata = shift_val(shift_t'(rel[1:0]), b);
            end
            default: ;   // NOP and the unused codes 52..63
        endcase
        o.status = status_of(cpu);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Directed rows. Starting from reset: A=X=Y=0, SP=FF, all flags clear.
    // Expected words are typed in where they are obvious; the rest come
    // from the predictor.
    // ------------------------------------------------------------------
    row_t directed_rows [N_DIRECTED];

    initial
    begin
        directed_rows = '{
            // quiet status right after reset
            '{OP_NOP,   8'h00, 1'b1, '{ACC_NONE, 8'h00, 8'h00, 1'b0, 8'h30}},
            // push status at the top of the stack page
            '{OP_PHP,   8'h00, 1'b1, '{ACC_PUSH, 8'h30, 8'hFF, 1'b0, 8'h30}},
            '{OP_PLA,   8'h80, 1'b1, '{ACC_PULL, 8'h00, 8'hFF, 1'b0, 8'hB0}},
            '{OP_LDA,   8'h00, 1'b1, '{ACC_NONE, 8'h00, 8'h00, 1'b0, 8'h32}},
            '{OP_LDX,   8'hFF, 1'b1, '{ACC_NONE, 8'h00, 8'h00, 1'b0, 8'hB0}},
            // TXS leaves flags alone
            '{OP_TXS,   8'h00, 1'b0, '0},
            // pull wraps SP from FF to 00; pulled bits 5:4 ignored
            '{OP_PLP,   8'hFF, 1'b1, '{ACC_PULL, 8'h00, 8'h00, 1'b0, 8'hFF}},
            // push wraps SP from 00 back to FF
            '{OP_PHP,   8'h00, 1'b0, '0},
            '{OP_PLP,   8'h30, 1'b1, '{ACC_PULL, 8'h00, 8'h00, 1'b0, 8'h30}},
            // signed overflow on ADC, then SBC and compares at the extremes
            '{OP_LDA,   8'h7F, 1'b0, '0},
            '{OP_ADC,   8'h01, 1'b0, '0},
            '{OP_SBC,   8'h00, 1'b0, '0},
            '{OP_CMP,   8'h80, 1'b0, '0},
            '{OP_BIT,   8'hC0, 1'b0, '0},
            '{OP_BVS,   8'h00, 1'b0, '0},
            '{OP_BCC,   8'h00, 1'b0, '0},
            '{OP_ROR_A, 8'h00, 1'b0, '0},
            '{OP_ASL_M, 8'h80, 1'b0, '0},
            '{OP_INC,   8'hFF, 1'b0, '0},
            '{OP_DEC,   8'h00, 1'b0, '0},
            '{OP_DEX,   8'h00, 1'b0, '0},
            '{OP_CPY,   8'hFF, 1'b0, '0},
            '{OP_STA,   8'h55, 1'b0, '0},
            // unused code behaves as a NOP
            '{6'd63,    8'hAA, 1'b0, '0},
            '{OP_LSR_M, 8'h01, 1'b0, '0}
        };
    end

    // ------------------------------------------------------------------
    // Shared scoreboard state. Handshakes are sampled at the falling edge,
    // where every signal is settled; a fire seen there is the word that the
    // next rising edge accepts.
    // ------------------------------------------------------------------
    bit   cmd_fire;
    bit   rsp_fire;
    int   words_taken;
    int   stalled_cycles;
    int   mismatches;
    bit   source_done;
    bit   offer_known;      // word on the bus is a directed row with a typed result
    res_t offer_want;
    res_t want;
    res_t got;
    res_t pending_results [$];
    logic calm;

    assign calm = (words_taken >= CALM_FROM) && (words_taken < CALM_TO);

    always @(negedge clk)
    begin
        cmd_fire = rst_n && cmd_bus.valid && cmd_bus.ready;
        rsp_fire = rst_n && rsp_bus.valid && rsp_bus.ready;

        if (cmd_fire)
        begin
            // predictor always runs so its state tracks the block
            want = execute_op(cmd_bus.operation, cmd_bus.operand);
            if (offer_known)
                want = offer_want;
            pending_results.push_back(want);
            words_taken++;
        end

        if (rsp_fire)
        begin
            got.kind   = access_t'(rsp_bus.access_kind);
            got.wdata  = rsp_bus.write_data;
            got.saddr  = rsp_bus.stack_address;
            got.taken  = rsp_bus.branch_taken;
            got.status = rsp_bus.status_byte;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no word, got kind=%0d wdata=%h saddr=%h",
                         $time, got.kind, got.wdata, got.saddr,
                         " taken=%0d status=%h", got.taken, got.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.kind != want.kind || got.wdata != want.wdata ||
                    got.saddr != want.saddr || got.taken != want.taken ||
                    got.status != want.status)
                begin
                    mismatches++;
                    $display("%0t: expected kind=%0d wdata=%h saddr=%h taken=%0d status=%h,",
                             $time, want.kind, want.wdata, want.saddr, want.taken,
                             want.status,
                             " got kind=%0d wdata=%h saddr=%h taken=%0d status=%h",
                             got.kind, got.wdata, got.saddr, got.taken, got.status);
                end
            end
        end

        if (cmd_fire || rsp_fire)
            stalled_cycles = 0;
        else
            stalled_cycles++;
    end

    // ------------------------------------------------------------------
    // Command side: directed rows first, then random words. Idles at random
    // except in the calm window; keeps offering through the long response
    // hold-off so the two pipeline registers fill and cmd.ready drops.
    // ------------------------------------------------------------------
    initial
    begin : word_source
        int         idx;
        bit         offering;
        logic [5:0] next_op;
        logic [7:0] next_arg;
        logic [7:0] corner_bytes [5];

        corner_bytes      = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
        cmd_bus.valid     = 1'b0;
        cmd_bus.operation = '0;
        cmd_bus.operand   = '0;
        offer_known       = 1'b0;
        offer_want        = '0;
        idx               = 0;
        offering          = 1'b0;
        @(posedge rst_n);
        while (idx < N_WORDS)
        begin
            @(posedge clk);
            if (cmd_fire)
            begin
                idx++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (idx < N_WORDS && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    if (idx < N_DIRECTED)
                    begin
                        next_op     = directed_rows[idx].op;
                        next_arg    = directed_rows[idx].arg;
                        offer_known = directed_rows[idx].known;
                        offer_want  = directed_rows[idx].want;
                    end
                    else
                    begin
                        // mostly defined codes, some of the unused ones
                        if ($urandom_range(9) == 0)
                            next_op = 6'($urandom_range(63, 52));
                        else
                            next_op = 6'($urandom_range(51, 0));
                        // a quarter of operands sit on the byte corners
                        if ($urandom_range(3) == 0)
                            next_arg = corner_bytes[$urandom_range(4)];
                        else
                            next_arg = 8'($urandom_range(255));
                        offer_known = 1'b0;
                    end
                    cmd_bus.valid     <= 1'b1;
                    cmd_bus.operation <= next_op;
                    cmd_bus.operand   <= next_arg;
                    offering = 1'b1;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
        source_done = 1'b1;
    end

    // ------------------------------------------------------------------
    // Response side: random back-pressure, one long hold-off
    // ------------------------------------------------------------------
    initial
    begin : word_sink
        int hold_left;
        bit held;

        rsp_bus.ready = 1'b0;
        hold_left     = 0;
        held          = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!held && words_taken >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                rsp_bus.ready <= 1'b0;
            end
            else
                rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: nothing accepted on either side for too long
    initial
    begin
        stalled_cycles = 0;
        wait (stalled_cycles >= STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Reset, then wait for the command side to finish and the results to drain
    initial
    begin
        mismatches  = 0;
        words_taken = 0;
        source_done = 1'b0;
        rst_n       = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        wait (source_done);
        while (pending_results.size() != 0)
            @(posedge clk);
        // any stray word showing up here is flagged by the scoreboard
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
